// ===== src/isort_pkg.sv =====
// isort_pkg: shared constants, payload structs, cell control struct and state
// enum for the insertion sorter. No dependencies.
package isort_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample_value;
      logic                         end_of_set;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         final_flag;
      logic                         overflow;
   } rsp_data_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                         insert_en;
      logic                         drain_en;
      logic signed [DATA_WIDTH-1:0] sample;
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage

// ===== src/isort_cell.sv =====
// isort_cell: one slot of the sorting chain. Compares the broadcast sample
// with its own value and shifts right on insert or left on drain. Uses isort_pkg.
module isort_cell
   import isort_pkg::*;
(
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic                         occupied,
   input  logic                         at_fill,
   input  logic                         prev_shift,
   input  logic signed [DATA_WIDTH-1:0] prev_value,
   input  logic signed [DATA_WIDTH-1:0] next_value,
   output logic                         shift_out,
   output logic signed [DATA_WIDTH-1:0] value
);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   // strict less-than keeps equal values in arrival order
   assign shift_out = occupied && (ctrl.sample < value_ff);
   assign value     = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain_en) begin
         value_in = next_value;
      end else if (ctrl.insert_en && (shift_out || at_fill)) begin
         value_in = prev_shift ? prev_value : ctrl.sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/insertion_sorter.sv =====
// insertion_sorter: top level with the chain of isort_cell slots, fill count,
// fill/drain control and the result register. Uses isort_pkg and isort_cell.
//
// Usage: values arrive on the req_ channel (req_valid, req_stall, req_data),
// one transfer per value. Each value is compared against every occupied slot
// in the same cycle and inserted in ascending order, so while a set is being
// filled the block takes one value per clock. Values beyond CAPACITY are
// dropped and the set's results carry overflow.
// A transfer with end_of_set is inserted like any other and then the chain
// drains: slot 0 moves into the result register and the chain shifts left,
// one result per cycle while rsp_stall does not hold the drain. The first
// result is valid once the state register has entered drain and the result
// register has then loaded slot 0. While draining, req_stall is high; it
// drops in the cycle after the final result is loaded, even if that result
// is still waiting in the output register.
// rsp_stall holds the result register and pauses the drain; nothing is lost.
// Reset (synchronous, active high) empties the chain and clears the flags;
// slot contents need no reset since only occupied slots are ever read.
module insertion_sorter
   import isort_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   state_type state_ff, state_in;
   logic [COUNT_WIDTH-1:0] fill_count_ff, fill_count_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic full;
   logic pop;
   logic last_pop;
   cell_ctrl_type ctrl;

   logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]          cell_shift;

   assign req_xfer = req_valid && !req_stall;
   assign full     = (fill_count_ff == COUNT_WIDTH'(CAPACITY));
   assign pop      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign last_pop = pop && (fill_count_ff == COUNT_WIDTH'(1));

   assign ctrl.insert_en = req_xfer && !full;
   assign ctrl.drain_en  = pop;
   assign ctrl.sample    = req_data.sample_value;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                         prev_shift;
         logic signed [DATA_WIDTH-1:0] prev_value;
         logic signed [DATA_WIDTH-1:0] next_value;

         if (i == 0) begin : g_first
            assign prev_shift = 1'b0;
            assign prev_value = req_data.sample_value;
         end else begin : g_inner
            assign prev_shift = cell_shift[i-1];
            assign prev_value = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign next_value = cell_value[i];
         end else begin : g_mid
            assign next_value = cell_value[i+1];
         end

         isort_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (COUNT_WIDTH'(i) < fill_count_ff),
            .at_fill    (COUNT_WIDTH'(i) == fill_count_ff),
            .prev_shift (prev_shift),
            .prev_value (prev_value),
            .next_value (next_value),
            .shift_out  (cell_shift[i]),
            .value      (cell_value[i])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_xfer && req_data.end_of_set) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (last_pop) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      unique case (state_ff)
         ST_FILL:  req_stall = 1'b0;
         ST_DRAIN: req_stall = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      dropped_in    = dropped_ff;
      if (ctrl.insert_en) begin
         fill_count_in = fill_count_ff + COUNT_WIDTH'(1);
      end else if (req_xfer) begin
         dropped_in = 1'b1;
      end
      if (pop) begin
         fill_count_in = fill_count_ff - COUNT_WIDTH'(1);
         if (last_pop) dropped_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = cell_value[0];
         rsp_data_in.final_flag   = (fill_count_ff == COUNT_WIDTH'(1));
         rsp_data_in.overflow     = dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         fill_count_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("fill count above capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> fill_count_ff != '0)
      else $error("draining an empty chain");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && full) |=> dropped_ff)
      else $error("dropped value not flagged");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      last_pop |=> (state_ff == ST_FILL) && (fill_count_ff == '0) && !dropped_ff)
      else $error("set not cleared after final result");

endmodule
